/* rtl/aeps_pkg.sv */
// Shared types and constants of the active/expired priority scheduler.
package aeps_pkg;

  localparam int TASK_ID_W = 8;
  localparam int LEVEL_W   = 4;
  localparam int PRIO_W    = 3;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 4;
  localparam int FIFO_DEPTH = 2;

  localparam logic CFG_NUM_LEVELS = 1'b0;
  localparam logic CFG_PREEMPT    = 1'b1;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    BK_RUN = 1'b0,
    BK_POP = 1'b1
  } bk_state_t;

  typedef struct packed {
    cmd_t                  command;
    logic [TASK_ID_W-1:0]  task_id;
    logic signed [3:0]     dynamic_priority;
    logic [3:0]            static_priority;
    logic                  running_valid;
    logic signed [3:0]     running_priority;
    logic [TIME_W-1:0]     running_deadline;
    logic [TIME_W-1:0]     current_time;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic                  task_valid;
    logic [TASK_ID_W-1:0]  next_task;
    logic [PRIO_W-1:0]     assigned_priority;
    logic                  to_expired;
    logic                  preempt;
    logic                  banks_swapped;
  } out_result_t;

  typedef struct packed {
    cmd_t                  command;
    logic                  range_err;
    logic                  to_exp;
    logic [LEVEL_W-1:0]    level;
    logic [PRIO_W-1:0]     aprio;
    logic                  preempt_cand;
    logic [TASK_ID_W-1:0]  task_id;
  } cls_t;

  typedef struct packed {
    logic valid;
    cls_t item;
  } cls_slot_t;

endpackage

/* rtl/aeps_front.sv */
// Front end: accepts transactions and classifies them for the queue engine.
module aeps_front import aeps_pkg::*; (
  input  logic               start,
  input  in_item_t           in_item,
  input  logic               q_full,
  input  logic [LEVEL_W-1:0] n_levels,
  input  logic               preempt_mode,
  output logic               busy,
  output logic               push,
  output cls_t               cls
);

  logic signed [5:0] prio_s;
  logic signed [5:0] n_s;
  logic              is_exp;
  logic              bad_dyn;
  logic              range_err;
  logic              cand;

  assign busy = q_full;
  assign push = start && !q_full;
  assign n_s  = $signed({2'b00, n_levels});

  always_comb begin
    is_exp  = 1'b0;
    bad_dyn = 1'b0;
    prio_s  = '0;
    if (in_item.dynamic_priority >= 4'sd0) begin
      prio_s = $signed({2'b00, in_item.dynamic_priority});
    end else if (in_item.dynamic_priority == -4'sd1) begin
      prio_s = $signed({2'b00, in_item.static_priority}) - 6'sd1;
      is_exp = 1'b1;
    end else begin
      bad_dyn = 1'b1;
    end
    range_err = bad_dyn || (prio_s < 6'sd0) || (prio_s >= n_s);
    cand = preempt_mode && in_item.running_valid
        && ($signed(in_item.dynamic_priority) > $signed(in_item.running_priority))
        && (in_item.running_deadline > in_item.current_time);
  end

  always_comb begin
    cls.command      = in_item.command;
    cls.task_id      = in_item.task_id;
    cls.range_err    = range_err;
    cls.to_exp       = is_exp && !range_err;
    cls.level        = n_levels - LEVEL_W'(1) - prio_s[LEVEL_W-1:0];
    cls.aprio        = range_err ? '0 : prio_s[PRIO_W-1:0];
    cls.preempt_cand = cand && !range_err;
  end

endmodule

/* rtl/aeps_fifo.sv */
// Two-entry queue of classified transactions between front end and engine.
module aeps_fifo import aeps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_t      push_item,
  input  logic      pop,
  output logic      full,
  output cls_slot_t head
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  cls_t          slot_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == NW'(FIFO_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/aeps_back.sv */
// Queue engine: per-level FIFO bookkeeping, task memory and result register.
module aeps_back import aeps_pkg::*; #(
  parameter int MAX_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LEVEL_W-1:0] n_levels,
  input  cls_slot_t          head,
  output logic               pop,
  output logic               out_strobe,
  output out_result_t        out_result
);

  localparam int NQ = 2 * MAX_LEVELS;
  localparam int QW = $clog2(NQ);
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NQ * QUEUE_DEPTH);
  localparam logic [QW-1:0] BANK_OFS = QW'(MAX_LEVELS);

  bk_state_t            state_r, state_nxt;
  logic                 active_r, active_nxt;
  logic [HW-1:0]        head_r [NQ];
  logic [HW-1:0]        head_nxt [NQ];
  logic [CW-1:0]        cnt_r [NQ];
  logic [CW-1:0]        cnt_nxt [NQ];
  logic                 out_strobe_r, out_strobe_nxt;
  out_result_t          out_r, out_nxt;
  out_result_t          pend_r, pend_nxt;
  logic [TASK_ID_W-1:0] mem [NQ * QUEUE_DEPTH];
  logic [TASK_ID_W-1:0] rd_data_r;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;

  logic [MAX_LEVELS-1:0] lo_ne, hi_ne, act_ne, exp_ne, sel_ne;
  logic                  swap, found, bank_use;
  logic [LEVEL_W-1:0]    idx;
  logic [QW-1:0]         q_add, q_pop, q_sel;
  logic [HW-1:0]         h_sel;
  logic [CW-1:0]         c_sel;
  logic [HW:0]           pos_sum;
  logic [HW-1:0]         pos;

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  always_comb begin
    for (int i = 0; i < MAX_LEVELS; i++) begin
      lo_ne[i] = (cnt_r[i] != '0) && (LEVEL_W'(i) < n_levels);
      hi_ne[i] = (cnt_r[MAX_LEVELS + i] != '0) && (LEVEL_W'(i) < n_levels);
    end
    act_ne   = active_r ? hi_ne : lo_ne;
    exp_ne   = active_r ? lo_ne : hi_ne;
    swap     = !(|act_ne);
    sel_ne   = swap ? exp_ne : act_ne;
    bank_use = active_r ^ swap;
    found    = |sel_ne;
    idx      = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (sel_ne[i]) begin
        idx = LEVEL_W'(i);
      end
    end
    q_pop = (bank_use ? BANK_OFS : '0) + QW'(idx);
    q_add = ((active_r ^ head.item.to_exp) ? BANK_OFS : '0) + QW'(head.item.level);
    q_sel = (head.item.command == CMD_NEXT) ? q_pop : q_add;
    h_sel = head_r[q_sel];
    c_sel = cnt_r[q_sel];
    pos_sum = (HW + 1)'(h_sel) + (HW + 1)'(c_sel);
    pos = (pos_sum >= (HW + 1)'(QUEUE_DEPTH)) ?
          HW'(pos_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(pos_sum);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RUN: begin
        if (head.valid && head.item.command == CMD_NEXT) begin
          state_nxt = BK_POP;
        end
      end
      BK_POP: begin
        state_nxt = BK_RUN;
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    active_nxt     = active_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    pend_nxt       = pend_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(pos);
    rd_addr        = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(h_sel);
    unique case (state_r)
      BK_RUN: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.command == CMD_ADD) begin
            out_strobe_nxt = 1'b1;
            out_nxt        = '0;
            if (head.item.range_err) begin
              out_nxt.status = ST_RANGE;
            end else begin
              out_nxt.assigned_priority = head.item.aprio;
              out_nxt.to_expired        = head.item.to_exp;
              if (c_sel == CW'(QUEUE_DEPTH)) begin
                out_nxt.status = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                cnt_nxt[q_sel] = c_sel + CW'(1);
                out_nxt.preempt = head.item.preempt_cand;
              end
            end
          end else begin
            active_nxt             = bank_use;
            pend_nxt               = '0;
            pend_nxt.banks_swapped = swap;
            pend_nxt.task_valid    = found;
            if (found) begin
              rd_en           = 1'b1;
              cnt_nxt[q_sel]  = c_sel - CW'(1);
              head_nxt[q_sel] = (h_sel == HW'(QUEUE_DEPTH - 1)) ? '0 : h_sel + HW'(1);
            end
          end
        end
      end
      BK_POP: begin
        out_strobe_nxt    = 1'b1;
        out_nxt           = pend_r;
        out_nxt.next_task = pend_r.task_valid ? rd_data_r : '0;
      end
      default: begin
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_RUN;
      active_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      out_strobe_r <= out_strobe_nxt;
      head_r       <= head_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= head.item.task_id;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* rtl/active_expired_priority_scheduler.sv */
// Top level of the active/expired multilevel priority scheduler.
// Every accepted transaction gives exactly one result, shown for one cycle with
// out_strobe; the receiver cannot stall it. A transaction is taken at a clock
// edge with start high and busy low and enters a two-entry queue in front of
// the queue engine. An add shows its result in the cycle after the edge at
// which the engine picks it up; a next waits for the registered read of the
// task memory in the BK_POP state. Adds sustain one per cycle, but the engine
// takes no new transaction while in BK_POP; busy rises while the queue is full.
module active_expired_priority_scheduler import aeps_pkg::*; #(
  parameter int MAX_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_result_t out_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0]   num_levels_r;
  logic               preempt_mode_r;
  logic [LEVEL_W-1:0] n_levels;
  logic               q_full;
  logic               push;
  logic               pop;
  cls_t               cls;
  cls_slot_t          q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r   <= CFG_W'(4);
      preempt_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_LEVELS: num_levels_r   <= cfg_data;
        CFG_PREEMPT:    preempt_mode_r <= cfg_data[0];
        default:        num_levels_r   <= num_levels_r;
      endcase
    end
  end

  always_comb begin
    if (num_levels_r == '0) begin
      n_levels = LEVEL_W'(1);
    end else if (32'(num_levels_r) > MAX_LEVELS) begin
      n_levels = LEVEL_W'(MAX_LEVELS);
    end else begin
      n_levels = num_levels_r;
    end
  end

  aeps_front u_front (
    .start        (start),
    .in_item      (in_item),
    .q_full       (q_full),
    .n_levels     (n_levels),
    .preempt_mode (preempt_mode_r),
    .busy         (busy),
    .push         (push),
    .cls          (cls)
  );

  aeps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (cls),
    .pop       (pop),
    .full      (q_full),
    .head      (q_head)
  );

  aeps_back #(
    .MAX_LEVELS  (MAX_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .n_levels   (n_levels),
    .head       (q_head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule
